[hdl/kmms_pkg.sv]
package kmms_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FIELD_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_GROUP_EXT  = 3'd2,
    CMD_ALL_EXT    = 3'd3,
    CMD_THRESHOLD  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ALL,
    MODE_GROUP,
    MODE_AT_OR_ABOVE,
    MODE_BELOW
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // zero one table row, step address
    logic write;     // apply add/remove from the input transaction
    logic start;     // latch query, reset best-so-far
    logic read;      // read one row, step address
    logic load_out;  // move best-so-far into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic addr_last;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/kmms_cmd_if.sv]
interface kmms_cmd_if #(
  parameter int unsigned ID_W = 10
);
  import kmms_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    entry_id;
  logic [FIELD_W-1:0] level;
  logic [FIELD_W-1:0] group;
  logic               upward;

  modport source (output valid, command, entry_id, level, group, upward, input ready);
  modport sink   (input valid, command, entry_id, level, group, upward, output ready);

endinterface

[hdl/kmms_rsp_if.sv]
interface kmms_rsp_if #(
  parameter int unsigned ID_W = 10
);

  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] result_id;

  modport source (output valid, found, result_id, input ready);
  modport sink   (input valid, found, result_id, output ready);

endinterface

[hdl/kmms_ctrl.sv]
module kmms_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [kmms_pkg::CMD_W-1:0] in_command_i,
  output logic                     in_ready_o,
  input  kmms_pkg::dp_status_t     status_i,
  output kmms_pkg::ctrl_cmd_t      cmd_o
);
  import kmms_pkg::*;

  state_e state_q, state_d;
  logic   is_update;
  logic   is_query;

  always_comb begin
    is_update = (in_command_i inside {CMD_ADD, CMD_REMOVE});
    is_query  = (in_command_i inside {CMD_GROUP_EXT, CMD_ALL_EXT, CMD_THRESHOLD});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.addr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && is_query) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.addr_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.write = in_valid_i && is_update;
        cmd_o.start = in_valid_i && is_query;
      end
      ST_SCAN: begin
        cmd_o.read = 1'b1;
      end
      ST_DRAIN: begin
        // last row is being compared
      end
      ST_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[hdl/kmms_datapath.sv]
module kmms_datapath #(
  parameter int unsigned ID_COUNT    = 1024,
  parameter int unsigned LEVEL_COUNT = 101,
  parameter int unsigned GROUP_COUNT = 101,
  parameter int unsigned ID_W        = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kmms_pkg::ctrl_cmd_t          cmd_i,
  input  logic [kmms_pkg::CMD_W-1:0]   in_command_i,
  input  logic [ID_W-1:0]              in_entry_id_i,
  input  logic [kmms_pkg::FIELD_W-1:0] in_level_i,
  input  logic [kmms_pkg::FIELD_W-1:0] in_group_i,
  input  logic                         in_upward_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         out_found_o,
  output logic [ID_W-1:0]              out_result_id_o,
  output kmms_pkg::dp_status_t         status_o
);
  import kmms_pkg::*;

  localparam int unsigned ROW_W = 1 + 2 * FIELD_W;  // {valid, level, group}

  localparam logic [ID_W:0]    IdLimit    = (ID_W + 1)'(ID_COUNT);
  localparam logic [ID_W-1:0]  IdLast     = ID_W'(ID_COUNT - 1);
  localparam logic [FIELD_W:0] LevelLimit = (FIELD_W + 1)'(LEVEL_COUNT);
  localparam logic [FIELD_W:0] GroupLimit = (FIELD_W + 1)'(GROUP_COUNT);

  logic [ROW_W-1:0] mem_q [ID_COUNT];

  logic               mem_we;
  logic [ID_W-1:0]    mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic [ROW_W-1:0]   rd_q;
  logic [ID_W-1:0]    rd_id_q;
  logic               cmp_v_q;

  logic [ID_W-1:0]    addr_q, addr_d;
  logic               addr_last;

  mode_e              mode_q;
  logic [FIELD_W-1:0] arg_q;
  logic               want_max_q;

  logic               have_q;
  logic [FIELD_W-1:0] best_level_q;
  logic [ID_W-1:0]    best_id_q;

  logic               out_valid_q;
  logic               out_found_q;
  logic [ID_W-1:0]    out_id_q;

  logic               id_ok;
  logic               rd_valid;
  logic [FIELD_W-1:0] rd_level;
  logic [FIELD_W-1:0] rd_group;
  logic               pass;
  logic               better;
  logic               take;

  assign addr_last = (addr_q == IdLast);

  always_comb begin
    if (addr_last) begin
      addr_d = '0;
    end else begin
      addr_d = addr_q + 1'b1;
    end
  end

  // table write: clearing pass, add, remove
  always_comb begin
    id_ok     = ({1'b0, in_entry_id_i} < IdLimit);
    mem_we    = 1'b0;
    mem_waddr = in_entry_id_i;
    mem_wdata = '0;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
    end else if (cmd_i.write) begin
      if (in_command_i == CMD_ADD) begin
        mem_we    = id_ok && ({1'b0, in_level_i} < LevelLimit) &&
                    ({1'b0, in_group_i} < GroupLimit);
        mem_wdata = {1'b1, in_level_i, in_group_i};
      end else begin
        mem_we = id_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_q    <= mem_q[addr_q];
      rd_id_q <= addr_q;
    end
  end

  // compare stage
  always_comb begin
    {rd_valid, rd_level, rd_group} = rd_q;
    case (mode_q)
      MODE_ALL:         pass = 1'b1;
      MODE_GROUP:       pass = (rd_group == arg_q);
      MODE_AT_OR_ABOVE: pass = (rd_level >= arg_q);
      MODE_BELOW:       pass = (rd_level < arg_q);
      default:          pass = 1'b0;
    endcase
    // ids arrive in ascending order, so ties on level go to the later id for max
    if (want_max_q) begin
      better = (rd_level >= best_level_q);
    end else begin
      better = (rd_level < best_level_q);
    end
    take = cmp_v_q && rd_valid && pass && (!have_q || better);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      arg_q <= (in_command_i == CMD_GROUP_EXT) ? in_group_i : in_level_i;
    end
    if (take) begin
      best_level_q <= rd_level;
      best_id_q    <= rd_id_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= have_q;
      out_id_q    <= have_q ? best_id_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      cmp_v_q     <= 1'b0;
      mode_q      <= MODE_ALL;
      want_max_q  <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear || cmd_i.read) begin
        addr_q <= addr_d;
      end else if (cmd_i.start) begin
        addr_q <= '0;
      end
      cmp_v_q <= cmd_i.read;
      if (cmd_i.start) begin
        have_q <= 1'b0;
        case (in_command_i)
          CMD_GROUP_EXT: begin
            mode_q     <= MODE_GROUP;
            want_max_q <= in_upward_i;
          end
          CMD_THRESHOLD: begin
            mode_q     <= in_upward_i ? MODE_AT_OR_ABOVE : MODE_BELOW;
            want_max_q <= !in_upward_i;
          end
          default: begin
            mode_q     <= MODE_ALL;
            want_max_q <= in_upward_i;
          end
        endcase
      end else if (take) begin
        have_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.addr_last = addr_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_found_o     = out_found_q;
  assign out_result_id_o = out_id_q;

endmodule

[hdl/keyed_min_max_search_table.sv]
// Operation: an add/remove is written to the table when accepted; a query reads the table
//   one row per cycle through its single read port, then passes compare and output stages.
// Throughput: one add/remove per cycle while the command channel is ready. A query keeps it
//   not ready until its result is loaded; a pending result does not block acceptance, only that load.
// Reset: asynchronous, active low. After reset the table is cleared one row per cycle,
//   with the command channel not ready.
module keyed_min_max_search_table #(
  parameter int unsigned ID_COUNT    = 1024,
  parameter int unsigned LEVEL_COUNT = 101,
  parameter int unsigned GROUP_COUNT = 101
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmms_cmd_if.sink   cmd_i,
  kmms_rsp_if.source rsp_o
);
  import kmms_pkg::*;

  localparam int unsigned ID_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  kmms_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .in_ready_o   (in_ready),
    .status_i     (dp_status),
    .cmd_o        (ctrl_cmd)
  );

  kmms_datapath #(
    .ID_COUNT    (ID_COUNT),
    .LEVEL_COUNT (LEVEL_COUNT),
    .GROUP_COUNT (GROUP_COUNT),
    .ID_W        (ID_W)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .in_command_i    (cmd_i.command),
    .in_entry_id_i   (cmd_i.entry_id),
    .in_level_i      (cmd_i.level),
    .in_group_i      (cmd_i.group),
    .in_upward_i     (cmd_i.upward),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_found_o     (rsp_o.found),
    .out_result_id_o (rsp_o.result_id),
    .status_o        (dp_status)
  );

  assign cmd_i.ready = in_ready;

`ifndef ASSERT_OFF
  // a query transaction blocks the command channel while the scan runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.start |=> !in_ready)
    else $error("command channel ready during table scan");

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load_out |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending result overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_cmd.clear, ctrl_cmd.write, ctrl_cmd.start, ctrl_cmd.read,
              ctrl_cmd.load_out}))
    else $error("conflicting datapath commands");

  // every result comes from a completed scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(ctrl_cmd.load_out))
    else $error("result valid without a completed scan");
`endif

endmodule
